>>> rtl/icu_pkg.sv
package icu_pkg;

  // Default operand width.
  localparam int DataWidthDef = 32;

  // Operation selector codes.
  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_SUB   = 3'd1,
    FN_MUL   = 3'd2,
    FN_DIV   = 3'd3,
    FN_POW   = 3'd4,
    FN_PRIME = 3'd5
  } func_e;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIV0    = 2'd1,
    ST_OVF     = 2'd2,
    ST_INVALID = 2'd3
  } st_e;

  // Operand sources and mode of the shared shift-add / restoring-divide engine.
  typedef enum logic [2:0] {
    ES_MUL_AB     = 3'd0,
    ES_MUL_ACC_SQ = 3'd1,
    ES_MUL_SQ_SQ  = 3'd2,
    ES_DIV_AB     = 3'd3,
    ES_DIV_A_D    = 3'd4
  } eng_sel_e;

  // Source of the value written into the result register.
  typedef enum logic [2:0] {
    RS_ADD  = 3'd0,
    RS_SUB  = 3'd1,
    RS_PROD = 3'd2,
    RS_QUOT = 3'd3,
    RS_ACC  = 3'd4,
    RS_ONE  = 3'd5,
    RS_ZERO = 3'd6
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     eng_start;
    eng_sel_e eng_sel;
    logic     pw_init;
    logic     acc_load;
    logic     sq_load;
    logic     exp_shift;
    logic     d_init;
    logic     d_step;
    logic     res_load;
    res_sel_e res_sel;
    st_e      st;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e func;
    logic  eng_busy;
    logic  b_zero;
    logic  div_ovf;
    logic  b_nonpos;
    logic  a_lt2;
    logic  a_lt4;
    logic  a_even;
    logic  exp_zero;
    logic  exp_lsb;
    logic  exp_last;
    logic  d_gt_q;
    logic  rem_zero;
  } sts_t;

endpackage

>>> rtl/integer_calculator_unit_top.sv
// Integer calculator: each transaction carries an operation selector and two signed
// operands and returns one result with a status. Add, subtract and invalid selectors
// pass from dispatch straight to the commit state; multiply and divide run on a shared
// serial engine that retires one operand bit per cycle. Power uses square-and-multiply
// on the same engine, up to about 2 * DataWidth engine passes for a large exponent.
// The primality test divides by odd trial divisors up to the square root, one engine
// pass per divisor. One transaction is worked on at a time; a new one is accepted
// while the previous result is still waiting in the output register.
module integer_calculator_unit_top import icu_pkg::*; #(
  parameter int DataWidth = DataWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  func_i,
  input  logic signed [DataWidth-1:0] operand_a_i,
  input  logic signed [DataWidth-1:0] operand_b_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DataWidth-1:0] result_o,
  output logic [1:0]                  status_o
);

  cmd_t cmd;
  sts_t sts;

  icu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  icu_datapath #(
    .DataWidth (DataWidth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (func_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o),
    .status_o    (status_o)
  );

endmodule

>>> rtl/icu_datapath.sv
module icu_datapath import icu_pkg::*; #(
  parameter int DataWidth = DataWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [2:0]                  func_i,
  input  logic signed [DataWidth-1:0] operand_a_i,
  input  logic signed [DataWidth-1:0] operand_b_i,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  output logic signed [DataWidth-1:0] result_o,
  output logic [1:0]                  status_o
);

  localparam int CntW = $clog2(DataWidth + 1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [CntW-1:0] CntFull = CntW'(DataWidth);

  // Operand and working registers.
  logic [2:0]           func_q;
  logic [DataWidth-1:0] a_q, b_q;
  logic [DataWidth-1:0] acc_q, sq_q, exp_q, d_q;
  logic [DataWidth-1:0] res_q, res_d;
  st_e                  st_q;

  // Shared serial engine registers.
  logic                 eng_busy_q;
  logic [CntW-1:0]      eng_cnt_q;
  logic                 eng_div_q;
  logic [DataWidth-1:0] eng_x_q, eng_y_q, eng_p_q;
  logic [DataWidth-1:0] eng_x_d, eng_y_d, eng_p_d;

  logic [DataWidth-1:0] start_x, start_y;
  logic                 start_div;
  logic [DataWidth-1:0] a_mag, b_mag, quot_s;
  logic [DataWidth:0]   rem_ext, dvs_ext, rem_diff;
  logic                 rem_ge;

  // Magnitudes for the signed divide.
  assign a_mag = a_q[DataWidth-1] ? (-a_q) : a_q;
  assign b_mag = b_q[DataWidth-1] ? (-b_q) : b_q;

  // Operand selection when the engine is started.
  always_comb begin
    start_x   = a_q;
    start_y   = b_q;
    start_div = 1'b0;
    case (cmd_i.eng_sel)
      ES_MUL_AB: begin
        start_x = a_q;
        start_y = b_q;
      end
      ES_MUL_ACC_SQ: begin
        start_x = sq_q;
        start_y = acc_q;
      end
      ES_MUL_SQ_SQ: begin
        start_x = sq_q;
        start_y = sq_q;
      end
      ES_DIV_AB: begin
        start_x   = a_mag;
        start_y   = b_mag;
        start_div = 1'b1;
      end
      ES_DIV_A_D: begin
        start_x   = a_q;
        start_y   = d_q;
        start_div = 1'b1;
      end
      default: begin
        start_x = a_q;
        start_y = b_q;
      end
    endcase
  end

  // One engine step: a shift-add multiply bit or a restoring divide bit.
  assign rem_ext  = {eng_p_q, eng_x_q[DataWidth-1]};
  assign dvs_ext  = {1'b0, eng_y_q};
  assign rem_diff = rem_ext - dvs_ext;
  assign rem_ge   = (rem_ext >= dvs_ext);

  always_comb begin
    if (eng_div_q) begin
      eng_x_d = {eng_x_q[DataWidth-2:0], rem_ge};
      eng_y_d = eng_y_q;
      eng_p_d = rem_ge ? rem_diff[DataWidth-1:0] : rem_ext[DataWidth-1:0];
    end else begin
      eng_x_d = eng_x_q << 1;
      eng_y_d = eng_y_q >> 1;
      eng_p_d = eng_p_q + (eng_y_q[0] ? eng_x_q : '0);
    end
  end

  // Engine control: busy for one step per operand bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_busy_q <= 1'b0;
      eng_cnt_q  <= '0;
    end else if (cmd_i.eng_start) begin
      eng_busy_q <= 1'b1;
      eng_cnt_q  <= CntFull;
    end else if (eng_busy_q) begin
      eng_cnt_q <= eng_cnt_q - CntOne;
      if (eng_cnt_q == CntOne) begin
        eng_busy_q <= 1'b0;
      end
    end
  end

  // Engine data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eng_start) begin
      eng_x_q   <= start_x;
      eng_y_q   <= start_y;
      eng_p_q   <= '0;
      eng_div_q <= start_div;
    end else if (eng_busy_q) begin
      eng_x_q <= eng_x_d;
      eng_y_q <= eng_y_d;
      eng_p_q <= eng_p_d;
    end
  end

  // Signed quotient from the unsigned engine result.
  assign quot_s = (a_q[DataWidth-1] ^ b_q[DataWidth-1]) ? (-eng_x_q) : eng_x_q;

  // Result selection.
  always_comb begin
    case (cmd_i.res_sel)
      RS_ADD:  res_d = a_q + b_q;
      RS_SUB:  res_d = a_q - b_q;
      RS_PROD: res_d = eng_p_q;
      RS_QUOT: res_d = quot_s;
      RS_ACC:  res_d = acc_q;
      RS_ONE:  res_d = DataWidth'(1);
      RS_ZERO: res_d = '0;
      default: res_d = '0;
    endcase
  end

  // Operand, loop and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
    end
    if (cmd_i.pw_init) begin
      acc_q <= DataWidth'(1);
      sq_q  <= a_q;
      exp_q <= b_q;
    end else begin
      if (cmd_i.acc_load) begin
        acc_q <= eng_p_q;
      end
      if (cmd_i.sq_load) begin
        sq_q <= eng_p_q;
      end
      if (cmd_i.exp_shift) begin
        exp_q <= exp_q >> 1;
      end
    end
    if (cmd_i.d_init) begin
      d_q <= DataWidth'(3);
    end else if (cmd_i.d_step) begin
      d_q <= d_q + DataWidth'(2);
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
      st_q  <= cmd_i.st;
    end
  end

  // Status towards the controller.
  always_comb begin
    sts_o.func     = func_e'(func_q);
    sts_o.eng_busy = eng_busy_q;
    sts_o.b_zero   = (b_q == '0);
    sts_o.div_ovf  = (a_q == {1'b1, {(DataWidth-1){1'b0}}}) && (&b_q);
    sts_o.b_nonpos = b_q[DataWidth-1] || (b_q == '0);
    sts_o.a_lt2    = a_q[DataWidth-1] || (a_q < DataWidth'(2));
    sts_o.a_lt4    = (a_q < DataWidth'(4));
    sts_o.a_even   = ~a_q[0];
    sts_o.exp_zero = (exp_q == '0);
    sts_o.exp_lsb  = exp_q[0];
    sts_o.exp_last = (exp_q[DataWidth-1:1] == '0);
    sts_o.d_gt_q   = (d_q > eng_x_q);
    sts_o.rem_zero = (eng_p_q == '0);
  end

  assign result_o = res_q;
  assign status_o = st_q;

endmodule

>>> rtl/icu_ctrl.sv
module icu_ctrl import icu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE        = 11'b000_0000_0001,
    S_DISPATCH    = 11'b000_0000_0010,
    S_MUL_WAIT    = 11'b000_0000_0100,
    S_DIV_WAIT    = 11'b000_0000_1000,
    S_PW_TEST     = 11'b000_0001_0000,
    S_PW_ACC_WAIT = 11'b000_0010_0000,
    S_PW_SQ       = 11'b000_0100_0000,
    S_PW_SQ_WAIT  = 11'b000_1000_0000,
    S_PR_DIV      = 11'b001_0000_0000,
    S_PR_WAIT     = 11'b010_0000_0000,
    S_DONE        = 11'b100_0000_0000
  } state_e;

  state_e   state_q, state_d;
  res_sel_e fin_sel_q, fin_sel_d;
  st_e      fin_st_q, fin_st_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next state and datapath commands.
  always_comb begin
    state_d       = state_q;
    fin_sel_d     = fin_sel_q;
    fin_st_d      = fin_st_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o         = '0;
    cmd_o.eng_sel = ES_MUL_AB;
    cmd_o.res_sel = fin_sel_q;
    cmd_o.st      = fin_st_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_d  = S_DONE;
        fin_st_d = ST_OK;
        case (sts_i.func)
          FN_ADD: fin_sel_d = RS_ADD;
          FN_SUB: fin_sel_d = RS_SUB;
          FN_MUL: begin
            cmd_o.eng_start = 1'b1;
            cmd_o.eng_sel   = ES_MUL_AB;
            state_d         = S_MUL_WAIT;
          end
          FN_DIV: begin
            fin_sel_d = RS_ZERO;
            if (sts_i.b_zero) begin
              fin_st_d = ST_DIV0;
            end else if (sts_i.div_ovf) begin
              fin_st_d = ST_OVF;
            end else begin
              cmd_o.eng_start = 1'b1;
              cmd_o.eng_sel   = ES_DIV_AB;
              state_d         = S_DIV_WAIT;
            end
          end
          FN_POW: begin
            if (sts_i.b_nonpos) begin
              fin_sel_d = RS_ONE;
            end else begin
              cmd_o.pw_init = 1'b1;
              state_d       = S_PW_TEST;
            end
          end
          FN_PRIME: begin
            if (sts_i.a_lt2) begin
              fin_sel_d = RS_ZERO;
            end else if (sts_i.a_lt4) begin
              fin_sel_d = RS_ONE;
            end else if (sts_i.a_even) begin
              fin_sel_d = RS_ZERO;
            end else begin
              cmd_o.d_init = 1'b1;
              state_d      = S_PR_DIV;
            end
          end
          default: begin
            fin_sel_d = RS_ZERO;
            fin_st_d  = ST_INVALID;
          end
        endcase
      end

      S_MUL_WAIT: begin
        if (!sts_i.eng_busy) begin
          fin_sel_d = RS_PROD;
          state_d   = S_DONE;
        end
      end

      S_DIV_WAIT: begin
        if (!sts_i.eng_busy) begin
          fin_sel_d = RS_QUOT;
          state_d   = S_DONE;
        end
      end

      // Square-and-multiply, least significant exponent bit first.
      S_PW_TEST: begin
        if (sts_i.exp_zero) begin
          fin_sel_d = RS_ACC;
          state_d   = S_DONE;
        end else if (sts_i.exp_lsb) begin
          cmd_o.eng_start = 1'b1;
          cmd_o.eng_sel   = ES_MUL_ACC_SQ;
          state_d         = S_PW_ACC_WAIT;
        end else begin
          state_d = S_PW_SQ;
        end
      end

      S_PW_ACC_WAIT: begin
        if (!sts_i.eng_busy) begin
          cmd_o.acc_load = 1'b1;
          state_d        = S_PW_SQ;
        end
      end

      // The final squaring is skipped once no exponent bits remain.
      S_PW_SQ: begin
        cmd_o.exp_shift = 1'b1;
        if (sts_i.exp_last) begin
          state_d = S_PW_TEST;
        end else begin
          cmd_o.eng_start = 1'b1;
          cmd_o.eng_sel   = ES_MUL_SQ_SQ;
          state_d         = S_PW_SQ_WAIT;
        end
      end

      S_PW_SQ_WAIT: begin
        if (!sts_i.eng_busy) begin
          cmd_o.sq_load = 1'b1;
          state_d       = S_PW_TEST;
        end
      end

      // Trial division by odd divisors until one divides evenly or the divisor passes the quotient.
      S_PR_DIV: begin
        cmd_o.eng_start = 1'b1;
        cmd_o.eng_sel   = ES_DIV_A_D;
        state_d         = S_PR_WAIT;
      end

      S_PR_WAIT: begin
        if (!sts_i.eng_busy) begin
          if (sts_i.d_gt_q) begin
            fin_sel_d = RS_ONE;
            fin_st_d  = ST_OK;
            state_d   = S_DONE;
          end else if (sts_i.rem_zero) begin
            fin_sel_d = RS_ZERO;
            fin_st_d  = ST_OK;
            state_d   = S_DONE;
          end else begin
            cmd_o.d_step = 1'b1;
            state_d      = S_PR_DIV;
          end
        end
      end

      // Commit into the output register once it is free.
      S_DONE: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Pending result selection.
  always_ff @(posedge clk_i) begin
    fin_sel_q <= fin_sel_d;
    fin_st_q  <= fin_st_d;
  end

endmodule

>>> rtl/icu_checker.sv
module icu_checker import icu_pkg::*; #(
  parameter int DataWidth = DataWidthDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [DataWidth-1:0] result_o,
  input logic [1:0]                  status_o
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Count of accepted transactions whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  // A transaction is worked on alone: the input stalls right after acceptance.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted while a transaction was in progress");

  // Every error status comes with a zero result.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> result_o == '0)
    else $error("non-zero result with an error status");

  // No result without an accepted transaction behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result shown without a pending transaction");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind integer_calculator_unit_top icu_checker #(
  .DataWidth (DataWidth)
) u_icu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .result_o    (result_o),
  .status_o    (status_o)
);
